@@ hdl/bpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the beacon presence tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package bpt_pkg;

  localparam int NUM_ENTRIES_DEF = 32;
  localparam int ADDR_W          = 50;
  localparam int TIME_W          = 32;
  localparam int MAX_OUT         = 32;
  localparam int CNT_W           = 6;
  localparam logic [CNT_W-1:0] COUNT_CAP = 6'd63;

  typedef enum logic [1:0] {
    CMD_SIGHT  = 2'd0,
    CMD_PERIOD = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SIGHT  = 2'd0,
    KIND_PERIOD = 2'd1,
    KIND_ENTRY  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_MIN_REPORTS = 1'b0,
    CFG_MIN_OBS     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rssi;
    logic [7:0]        status;
    logic [1:0]        battery;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        index;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rssi;
    logic [1:0]        battery;
    logic [7:0]        status;
    logic [7:0]        rcount;
    logic [TIME_W-1:0] observed;
    logic              following;
    logic [CNT_W-1:0]  nearby;
    logic [CNT_W-1:0]  follow_cnt;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/beacon_presence_tracker_top.sv @@
// ----------------------------------------------------------------------------
// beacon_presence_tracker_top
// Table of beacon sightings with per-period presence reports.
// ----------------------------------------------------------------------------
// Input channel: queue style push/full; one beat per command. A two-deep
// input queue decouples the input from the table engine.
// Result channel: empty/pop; result fields are valid while empty is low.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready. Write only while the block is idle.
// Sequencing: a sighting runs a serial scan over the table for match, free
// slot and oldest entry, then a write and an output state; a period start
// goes straight to the output state; a report counts over every entry, then
// lists seen entries in order, at most one beat per cycle while not stalled.
// Reset clears all valid and seen marks and loads the default thresholds.
// When the receiver stalls, the engine holds its single output register
// and the input queue fills and raises full.
// Unknown commands are dropped without a result.
// ----------------------------------------------------------------------------
`default_nettype none
module beacon_presence_tracker_top #(
  parameter int NUM_ENTRIES = bpt_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [49:0] in_device_address,
  input  wire logic signed [7:0] in_signal_strength,
  input  wire logic [7:0]  in_status_value,
  input  wire logic [1:0]  in_battery_code,
  input  wire logic [31:0] in_now_seconds,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic [4:0]       out_entry_index,
  output logic [49:0]      out_address_out,
  output logic signed [7:0] out_rssi_out,
  output logic [1:0]       out_battery_out,
  output logic [7:0]       out_status_out,
  output logic [7:0]       out_report_count,
  output logic [31:0]      out_observed_seconds,
  output logic             out_following,
  output logic [5:0]       out_near_total,
  output logic [5:0]       out_follow_total,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);
  import bpt_pkg::*;

  item_t   item, q_item;
  result_t res;
  logic    q_valid, q_take, res_valid;
  logic [7:0]  min_reports_r;
  logic [23:0] min_obs_r;

  assign item = '{command: in_command, addr: in_device_address,
                  rssi: in_signal_strength, status: in_status_value,
                  battery: in_battery_code, now: in_now_seconds};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_reports_r <= 8'd3;
      min_obs_r     <= 24'd600;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_REPORTS: min_reports_r <= cfg_data[7:0];
        CFG_MIN_OBS:     min_obs_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  bpt_front u_front (
    .clk, .rst_n, .push, .item, .full, .q_valid, .q_item, .q_take
  );

  bpt_back #(.NUM_ENTRIES(NUM_ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take,
    .min_reports(min_reports_r), .min_obs(min_obs_r),
    .res_valid, .res, .res_take(pop)
  );

  assign empty                = !res_valid;
  assign out_kind             = res.kind;
  assign out_entry_index      = res.index;
  assign out_address_out      = res.addr;
  assign out_rssi_out         = res.rssi;
  assign out_battery_out      = res.battery;
  assign out_status_out       = res.status;
  assign out_report_count     = res.rcount;
  assign out_observed_seconds = res.observed;
  assign out_following        = res.following;
  assign out_near_total       = res.nearby;
  assign out_follow_total     = res.follow_cnt;
  assign out_last             = res.last;

endmodule
`default_nettype wire

@@ hdl/bpt_front.sv @@
// ----------------------------------------------------------------------------
// bpt_front
// Input stage: drops unknown commands and queues items for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none
module bpt_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  bpt_pkg::item_t      item,
  output logic                full,
  output logic                q_valid,
  output bpt_pkg::item_t      q_item,
  input  wire logic           q_take
);
  import bpt_pkg::*;

  item_t      buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       acc, keep;

  assign full    = (cnt_r == 2'd2);
  assign acc     = push && !full;
  assign keep    = acc && (item.command != CMD_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    if (keep) begin
      wr_nxt = ~wr_r;
    end
    if (q_take && q_valid) begin
      rd_nxt = ~rd_r;
    end
    cnt_nxt = cnt_r + {1'b0, keep} - {1'b0, q_take && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (keep) begin
      buf_r[wr_r] <= item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/bpt_back.sv @@
// ----------------------------------------------------------------------------
// bpt_back
// Table engine: entry storage, address match, victim choice, report walk.
// ----------------------------------------------------------------------------
`default_nettype none
module bpt_back #(
  parameter int NUM_ENTRIES = bpt_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  bpt_pkg::item_t       q_item,
  output logic                 q_take,
  input  wire logic [7:0]      min_reports,
  input  wire logic [23:0]     min_obs,
  output logic                 res_valid,
  output bpt_pkg::result_t     res,
  input  wire logic            res_take
);
  import bpt_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WRITE, ST_COUNT, ST_LIST, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_ENTRIES-1:0] valid_r, seen_r;
  logic [ADDR_W-1:0] addr_r  [NUM_ENTRIES];
  logic [7:0]        rssi_r  [NUM_ENTRIES];
  logic [1:0]        batt_r  [NUM_ENTRIES];
  logic [7:0]        stat_r  [NUM_ENTRIES];
  logic [7:0]        rcnt_r  [NUM_ENTRIES];
  logic [TIME_W-1:0] first_r [NUM_ENTRIES];
  logic [TIME_W-1:0] lastt_r [NUM_ENTRIES];

  item_t             cur_r;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     sel_r, sel_nxt;
  logic [TIME_W-1:0] best_r, best_nxt;
  logic              hit_r, hit_nxt, free_r, free_nxt;
  logic [CW-1:0]     near_r, near_nxt, fol_r, fol_nxt;
  logic [5:0]        sent_r, sent_nxt;
  logic [NUM_ENTRIES-1:0] match;
  logic              fol_i;
  result_t           out_r, out_nxt;
  logic              ov_r, ov_nxt;
  logic [TIME_W-1:0] obs_i;
  logic [CNT_W-1:0]  near_s, fol_s;
  logic              more;

  // Per-entry compare runs in parallel; priority is resolved by the scan.
  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      match[k] = valid_r[k] && (addr_r[k] == cur_r.addr);
    end
  end

  assign obs_i = lastt_r[idx_r] - first_r[idx_r];
  assign fol_i = valid_r[idx_r] && seen_r[idx_r] && (rcnt_r[idx_r] >= min_reports)
                 && (obs_i >= {8'd0, min_obs});
  assign near_s = (near_r > CW'(COUNT_CAP)) ? COUNT_CAP : CNT_W'(near_r);
  assign fol_s  = (fol_r > CW'(COUNT_CAP)) ? COUNT_CAP : CNT_W'(fol_r);
  assign q_take = (state_r == ST_IDLE) && q_valid;
  assign res_valid = ov_r;
  assign res = out_r;

  // Are there more seen entries above idx_r to list?
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (IW'(k) > idx_r && valid_r[k] && seen_r[k]) more = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    sel_nxt = sel_r;
    best_nxt = best_r;
    hit_nxt = hit_r;
    free_nxt = free_r;
    near_nxt = near_r;
    fol_nxt = fol_r;
    sent_nxt = sent_r;
    out_nxt = out_r;
    ov_nxt = ov_r && !res_take;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          near_nxt = '0;
          fol_nxt = '0;
          sent_nxt = '0;
          sel_nxt = '0;
          best_nxt = lastt_r[0];
          case (q_item.command)
            CMD_SIGHT:  state_nxt = ST_SCAN;
            CMD_PERIOD: state_nxt = ST_OUT;
            CMD_REPORT: state_nxt = ST_COUNT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        // Walk entries: first hit, else first free, else oldest last-seen.
        if (!hit_r) begin
          if (match[idx_r]) begin
            hit_nxt = 1'b1;
            sel_nxt = idx_r;
          end else if (!free_r && !valid_r[idx_r]) begin
            free_nxt = 1'b1;
            sel_nxt = idx_r;
          end else if (!free_r && lastt_r[idx_r] < best_r) begin
            best_nxt = lastt_r[idx_r];
            sel_nxt = idx_r;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        idx_nxt = sel_r;
        state_nxt = ST_OUT;
      end
      ST_COUNT: begin
        if (valid_r[idx_r] && seen_r[idx_r]) begin
          near_nxt = near_r + 1'b1;
          if (fol_i) fol_nxt = fol_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        if (!ov_r || res_take) begin
          if (near_r == '0) begin
            out_nxt = '0;
            out_nxt.kind = KIND_EMPTY;
            out_nxt.follow_cnt = fol_s;
            out_nxt.last = 1'b1;
            ov_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if (valid_r[idx_r] && seen_r[idx_r]) begin
              out_nxt.kind = KIND_ENTRY;
              out_nxt.index = 5'(idx_r);
              out_nxt.addr = addr_r[idx_r];
              out_nxt.rssi = rssi_r[idx_r];
              out_nxt.battery = batt_r[idx_r];
              out_nxt.status = stat_r[idx_r];
              out_nxt.rcount = rcnt_r[idx_r];
              out_nxt.observed = obs_i;
              out_nxt.following = fol_i;
              out_nxt.nearby = near_s;
              out_nxt.follow_cnt = fol_s;
              out_nxt.last = !more || (sent_r == 6'(MAX_OUT - 1)) || (idx_r == LAST_IDX);
              ov_nxt = 1'b1;
              sent_nxt = sent_r + 1'b1;
              if (out_nxt.last) state_nxt = ST_IDLE;
            end
            idx_nxt = idx_r + 1'b1;
            if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || res_take) begin
          out_nxt = '0;
          out_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          if (cur_r.command == CMD_PERIOD) begin
            out_nxt.kind = KIND_PERIOD;
          end else begin
            out_nxt.kind = KIND_SIGHT;
            out_nxt.index = 5'(idx_r);
            out_nxt.addr = addr_r[idx_r];
            out_nxt.rssi = rssi_r[idx_r];
            out_nxt.battery = batt_r[idx_r];
            out_nxt.status = stat_r[idx_r];
            out_nxt.rcount = rcnt_r[idx_r];
            out_nxt.observed = obs_i;
            out_nxt.following = fol_i;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      seen_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (state_r == ST_IDLE && q_valid && q_item.command == CMD_PERIOD) begin
        seen_r <= '0;
      end
      if (state_r == ST_WRITE) begin
        valid_r[sel_r] <= 1'b1;
        seen_r[sel_r]  <= 1'b1;
      end
    end
    if (state_r == ST_IDLE && q_valid) cur_r <= q_item;
    idx_r  <= idx_nxt;
    sel_r  <= sel_nxt;
    best_r <= best_nxt;
    hit_r  <= hit_nxt;
    free_r <= free_nxt;
    near_r <= near_nxt;
    fol_r  <= fol_nxt;
    sent_r <= sent_nxt;
    out_r  <= out_nxt;
    if (state_r == ST_WRITE) begin
      rssi_r[sel_r]  <= cur_r.rssi;
      stat_r[sel_r]  <= cur_r.status;
      batt_r[sel_r]  <= cur_r.battery;
      lastt_r[sel_r] <= cur_r.now;
      if (!hit_r) begin
        addr_r[sel_r]  <= cur_r.addr;
        first_r[sel_r] <= cur_r.now;
        rcnt_r[sel_r]  <= 8'd1;
      end else if (!seen_r[sel_r] && rcnt_r[sel_r] != 8'hFF) begin
        rcnt_r[sel_r] <= rcnt_r[sel_r] + 8'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/bpt_checker.sv @@
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bpt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] out_kind,
  input wire logic       out_last,
  input wire logic [5:0] out_near_total,
  input wire logic       out_following
);
  import bpt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_kind))
    else $error("result dropped while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_SIGHT || out_kind == KIND_PERIOD ||
                out_kind == KIND_EMPTY)) |-> out_last)
    else $error("single result without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_EMPTY) |-> out_near_total == 6'd0)
    else $error("empty report with nonzero count");

  a_entry_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ENTRY) |-> out_near_total != 6'd0)
    else $error("report entry with zero count");

  a_period_nf: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_PERIOD) |-> !out_following)
    else $error("period result flagged following");

endmodule

bind beacon_presence_tracker_top bpt_checker u_bpt_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_last, .out_near_total,
  .out_following
);
`default_nettype wire

@@ tb/sv/tb_beacon_presence_tracker_top.sv @@
// ----------------------------------------------------------------------------
// tb_beacon_presence_tracker_top
// Self-checking bench for the beacon presence tracker. It drives a directed
// table and then random traffic, predicts every result beat with a model of
// the sighting table, and compares each popped beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_beacon_presence_tracker_top;
  import bpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 32;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    logic [1:0]  command;
    logic [49:0] addr;
    logic [7:0]  rssi;
    logic [7:0]  status;
    logic [1:0]  battery;
    logic [31:0] now;
  } sighting_t;

  // directed row: stimulus plus an optional typed expectation
  typedef struct {
    sighting_t item;
    bit        has_exp;
    result_t   exp;
  } dir_row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [1:0] in_command;
  logic [49:0] in_device_address;
  logic signed [7:0] in_signal_strength;
  logic [7:0] in_status_value;
  logic [1:0] in_battery_code;
  logic [31:0] in_now_seconds;
  logic [1:0] out_kind;
  logic [4:0] out_entry_index;
  logic [49:0] out_address_out;
  logic signed [7:0] out_rssi_out;
  logic [1:0] out_battery_out;
  logic [7:0] out_status_out, out_report_count;
  logic [31:0] out_observed_seconds;
  logic out_following, out_last;
  logic [5:0] out_near_total, out_follow_total;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [23:0] cfg_data;

  beacon_presence_tracker_top u_top (
    .clk, .rst_n, .push, .full, .in_command, .in_device_address,
    .in_signal_strength, .in_status_value, .in_battery_code, .in_now_seconds,
    .empty, .pop, .out_kind, .out_entry_index, .out_address_out, .out_rssi_out,
    .out_battery_out, .out_status_out, .out_report_count, .out_observed_seconds,
    .out_following, .out_near_total, .out_follow_total, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // table shadow
  bit          tab_valid [NENT];
  bit          tab_seen  [NENT];
  logic [49:0] tab_addr  [NENT];
  logic [7:0]  tab_rssi  [NENT];
  logic [1:0]  tab_batt  [NENT];
  logic [7:0]  tab_stat  [NENT];
  logic [7:0]  tab_rcnt  [NENT];
  logic [31:0] tab_first [NENT];
  logic [31:0] tab_last  [NENT];
  logic [7:0]  thr_reports;
  logic [23:0] thr_observed;

  result_t    pending_beats[$];
  result_t    typed_beats[$];
  bit         typed_flags[$];
  logic [49:0] addr_pool[$];
  int  errors;
  int  cycles;
  int  send_idle, recv_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bit entry_follows(int i);
    return tab_valid[i] && tab_seen[i] && tab_rcnt[i] >= thr_reports &&
           (tab_last[i] - tab_first[i]) >= {8'd0, thr_observed};
  endfunction

  function automatic result_t entry_beat(logic [1:0] kind, int i);
    result_t r;
    r = '0;
    r.kind = kind;
    r.index = i[4:0];
    r.addr = tab_addr[i];
    r.rssi = tab_rssi[i];
    r.battery = tab_batt[i];
    r.status = tab_stat[i];
    r.rcount = tab_rcnt[i];
    r.observed = tab_last[i] - tab_first[i];
    r.following = entry_follows(i);
    return r;
  endfunction

  // apply one item to the shadow table and queue its result beats
  function automatic void predict_item(sighting_t it, bit has_exp, result_t exp);
    int hit, n;
    logic [5:0] nearby, follow;
    result_t r;
    result_t outs[$];
    case (it.command)
      CMD_SIGHT: begin
        hit = -1;
        for (int i = 0; i < NENT; i++)
          if (hit < 0 && tab_valid[i] && tab_addr[i] == it.addr) hit = i;
        if (hit < 0) begin
          for (int i = 0; i < NENT; i++)
            if (hit < 0 && !tab_valid[i]) hit = i;
          if (hit < 0) begin
            hit = 0;
            for (int i = 1; i < NENT; i++)
              if (tab_last[i] < tab_last[hit]) hit = i;
          end
          tab_valid[hit] = 1'b1;
          tab_seen[hit] = 1'b0;
          tab_rcnt[hit] = 8'd0;
          tab_addr[hit] = it.addr;
          tab_first[hit] = it.now;
        end
        tab_rssi[hit] = it.rssi;
        tab_stat[hit] = it.status;
        tab_batt[hit] = it.battery;
        tab_last[hit] = it.now;
        if (!tab_seen[hit]) begin
          tab_seen[hit] = 1'b1;
          if (tab_rcnt[hit] != 8'hFF) tab_rcnt[hit]++;
        end
        r = entry_beat(KIND_SIGHT, hit);
        r.last = 1'b1;
        outs.push_back(r);
      end
      CMD_PERIOD: begin
        for (int i = 0; i < NENT; i++) tab_seen[i] = 1'b0;
        r = '0;
        r.kind = KIND_PERIOD;
        r.last = 1'b1;
        outs.push_back(r);
      end
      CMD_REPORT: begin
        nearby = '0;
        follow = '0;
        for (int i = 0; i < NENT; i++)
          if (tab_valid[i] && tab_seen[i]) begin
            nearby++;
            if (entry_follows(i)) follow++;
          end
        if (nearby == 0) begin
          r = '0;
          r.kind = KIND_EMPTY;
          r.follow_cnt = follow;
          r.last = 1'b1;
          outs.push_back(r);
        end else begin
          for (int i = 0; i < NENT; i++)
            if (tab_valid[i] && tab_seen[i]) begin
              r = entry_beat(KIND_ENTRY, i);
              r.nearby = nearby;
              r.follow_cnt = follow;
              outs.push_back(r);
            end
          n = outs.size();
          outs[n-1].last = 1'b1;
        end
      end
      default: ;
    endcase
    foreach (outs[k]) begin
      pending_beats.push_back(outs[k]);
      typed_flags.push_back(has_exp && k == 0);
      typed_beats.push_back(exp);
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // receiver: pop at random, check each accepted beat
  always @(posedge clk) begin
    result_t want;
    result_t typed_b;
    bit      use_typed;
    if (rst_n && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_beats.pop_front();
        use_typed = typed_flags.pop_front();
        typed_b = typed_beats.pop_front();
        // rows with a typed expectation are checked against it
        if (use_typed) want = typed_b;
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("entry_index", 64'(want.index), 64'(out_entry_index));
        check_field("address_out", 64'(want.addr), 64'(out_address_out));
        check_field("rssi_out", 64'(want.rssi), 64'($unsigned(out_rssi_out)));
        check_field("battery_out", 64'(want.battery), 64'(out_battery_out));
        check_field("status_out", 64'(want.status), 64'(out_status_out));
        check_field("report_count", 64'(want.rcount), 64'(out_report_count));
        check_field("observed_seconds", 64'(want.observed),
                    64'(out_observed_seconds));
        check_field("following", 64'(want.following), 64'(out_following));
        check_field("near_total", 64'(want.nearby), 64'(out_near_total));
        check_field("follow_total", 64'(want.follow_cnt), 64'(out_follow_total));
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(sighting_t it, bit has_exp, result_t exp);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_command <= it.command;
    in_device_address <= it.addr;
    in_signal_strength <= it.rssi;
    in_status_value <= it.status;
    in_battery_code <= it.battery;
    in_now_seconds <= it.now;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(it, has_exp, exp);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    // a dropped unknown command may still be in flight
    repeat (3 * NENT + 10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MIN_REPORTS) thr_reports = val[7:0];
    else thr_observed = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic sighting_t make_item(logic [1:0] c, logic [49:0] a, logic [7:0] rs,
                                          logic [7:0] st, logic [1:0] b, logic [31:0] t);
    sighting_t it;
    it.command = c; it.addr = a; it.rssi = rs; it.status = st; it.battery = b; it.now = t;
    return it;
  endfunction

  function automatic sighting_t random_item(int mode);
    sighting_t it;
    int pick;
    pick = $urandom_range(99);
    it.command = CMD_SIGHT;
    if (pick >= 90) it.command = CMD_PERIOD;
    else if (pick >= 80) it.command = CMD_REPORT;
    else if (pick >= 78) it.command = CMD_NONE;
    it.addr = 50'({$urandom, $urandom});
    if (addr_pool.size() != 0 && $urandom_range(99) < 70)
      it.addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
    it.rssi = 8'($urandom);
    it.status = 8'($urandom);
    it.battery = 2'($urandom);
    // mode 1 uses a narrow clock range so ties and small spans are common
    it.now = (mode == 1) ? $urandom_range(1200) : $urandom;
    return it;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    result_t e;
    sighting_t it;
    rst_n = 1'b0;
    push = 1'b0; pop = 1'b0; cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_command = '0; in_device_address = '0; in_signal_strength = '0;
    in_status_value = '0; in_battery_code = '0; in_now_seconds = '0;
    errors = 0; cycles = 0;
    send_idle = 11; recv_idle = 46;
    foreach (tab_valid[i]) begin
      tab_valid[i] = 1'b0; tab_seen[i] = 1'b0;
    end
    thr_reports = 8'd3;
    thr_observed = 24'd600;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // report on an empty table, then a period start
    e = '0; e.kind = KIND_EMPTY; e.last = 1'b1;
    dir_rows.push_back('{make_item(CMD_REPORT, '0, '0, '0, '0, '0), 1'b1, e});
    e = '0; e.kind = KIND_PERIOD; e.last = 1'b1;
    dir_rows.push_back('{make_item(CMD_PERIOD, '1, '1, '1, '1, '1), 1'b1, e});
    // first sighting lands in entry 0 with fields at extremes
    e = '0; e.kind = KIND_SIGHT; e.addr = '1; e.rssi = 8'h80; e.status = 8'hFF;
    e.battery = 2'd3; e.rcount = 8'd1; e.last = 1'b1;
    dir_rows.push_back('{make_item(CMD_SIGHT, '1, 8'h80, 8'hFF, 2'd3, 32'hFFFF_FFFF),
                         1'b1, e});
    dir_rows.push_back('{make_item(CMD_SIGHT, '0, 8'h7F, 8'h00, 2'd0, 32'd0), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_SIGHT, '1, 8'h00, 8'h55, 2'd1, 32'd5), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_NONE, '1, '1, '1, '1, '1), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_REPORT, '0, '0, '0, '0, '0), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_PERIOD, '0, '0, '0, '0, '0), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_SIGHT, '0, 8'hAA, 8'h12, 2'd2, 32'd700), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_PERIOD, '0, '0, '0, '0, '0), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_SIGHT, '0, 8'h01, 8'h34, 2'd3, 32'd900), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_REPORT, '0, '0, '0, '0, '0), 1'b0, e});
    // period with nothing seen: report empty with counts zero
    dir_rows.push_back('{make_item(CMD_PERIOD, '0, '0, '0, '0, '0), 1'b0, e});
    dir_rows.push_back('{make_item(CMD_REPORT, '0, '0, '0, '0, '0), 1'b0, e});
    foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].has_exp, dir_rows[k].exp);
    drain_and_settle();

    // fill all entries then force evictions, with ties on last-seen
    write_reg(CFG_MIN_REPORTS, 24'd0);
    write_reg(CFG_MIN_OBS, 24'd0);
    for (int k = 0; k < 36; k++) begin
      it = make_item(CMD_SIGHT, 50'h100 + k, 8'($urandom), 8'($urandom), 2'($urandom),
                     32'd50);
      send_item(it, 1'b0, e);
    end
    send_item(make_item(CMD_REPORT, '0, '0, '0, '0, '0), 1'b0, e);
    drain_and_settle();

    // random phases across threshold settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MIN_REPORTS, 24'd3); write_reg(CFG_MIN_OBS, 24'd600); end
        1: begin write_reg(CFG_MIN_REPORTS, 24'd255); write_reg(CFG_MIN_OBS, 24'hFFFFFF); end
        2: begin write_reg(CFG_MIN_REPORTS, 24'd1); write_reg(CFG_MIN_OBS, 24'd100); end
        default: begin
          write_reg(CFG_MIN_REPORTS, 24'($urandom_range(4)));
          write_reg(CFG_MIN_OBS, 24'($urandom));
        end
      endcase
      if (ph == 2) begin send_idle = 46; recv_idle = 11; end
      if (ph == 3) begin send_idle = 0; recv_idle = 0; end
      addr_pool.delete();
      for (int k = 0; k < 40; k++) addr_pool.push_back(50'({$urandom, $urandom}));
      for (int k = 0; k < 82; k++) send_item(random_item(ph % 2), 1'b0, e);
      drain_and_settle();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
